[rtl/core/hufd_pkg.sv]
// Shared types and constants of the Huffman tree stream decoder.
package hufd_pkg;

    localparam int TREE_BYTES = 512;
    localparam int TREE_AW    = $clog2(TREE_BYTES);
    // Child and table-limit arithmetic width: one bit above the 9-bit table index.
    localparam int IDX_W      = 10;
    localparam int LEN_W      = 25;
    localparam int BIT_CNT_W  = 5;

    localparam logic [IDX_W-1:0]     NODE_LIMIT_MAX = IDX_W'(TREE_BYTES);
    localparam logic [TREE_AW-1:0]   ROOT_NODE      = TREE_AW'(1);
    localparam logic [BIT_CNT_W-1:0] LAST_BIT       = BIT_CNT_W'(31);

    localparam logic CMD_TREE = 1'b0;
    localparam logic CMD_DATA = 1'b1;

    localparam logic MODE_NIBBLE = 1'b0;
    localparam logic MODE_BYTE   = 1'b1;

    localparam logic REG_MODE   = 1'b0;
    localparam logic REG_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_BAD_NODE  = 2'd1,
        ERR_EARLY_END = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DESC,
        ST_SYM,
        ST_END,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic        cmd;
        logic [8:0]  tree_index;
        logic [7:0]  tree_byte;
        logic [31:0] data_word;
        logic        final_word;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_word;
        logic       stream_done;
        logic [1:0] error_code;
    } result_t;

    // A result before its end-of-word flag is known.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       stream_done;
        logic [1:0] error_code;
    } partial_t;

    typedef struct packed {
        logic     push;
        logic     flush;
        partial_t res;
    } gen_t;

endpackage

[rtl/core/hufd_out_stage.sv]
// Result holding stage: holds back each result so the last of a word can be flagged.
module hufd_out_stage
    import hufd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  gen_t    gen,
    output logic    ready,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic     hold_valid_reg, hold_valid_next;
    partial_t hold_reg, hold_next;
    logic     out_valid_reg, out_valid_next;
    result_t  out_reg, out_next;

    assign ready        = !hold_valid_reg || !out_valid_reg || !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        out_valid_next  = out_valid_reg && result_stall;
        out_next        = out_reg;
        if (gen.push)
        begin
            // A newer result means the held one is not the last of its word.
            if (hold_valid_reg)
            begin
                out_valid_next = 1'b1;
                out_next       = '{hold_reg.out_byte, 1'b0, hold_reg.stream_done,
                                   hold_reg.error_code};
            end
            hold_valid_next = 1'b1;
            hold_next       = gen.res;
        end
        else if (gen.flush && hold_valid_reg)
        begin
            out_valid_next  = 1'b1;
            out_next        = '{hold_reg.out_byte, 1'b1, hold_reg.stream_done,
                                hold_reg.error_code};
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_reg <= hold_next;
        out_reg  <= out_next;
    end

endmodule

[rtl/core/huffman_tree_stream_decoder.sv]
// Top level of the Huffman tree stream decoder: tree memory, bit walker and control.
//
//  Channel   Signals                              Direction  Transfer when
//  item      item_valid, item_stall, item         in         item_valid && !item_stall
//  result    result_valid, result_stall, result   out        result_valid && !result_stall
//  config    cfg_we, cfg_index, cfg_data          in         cfg_we
//
// A tree byte is written in the cycle that accepts it. A data word is walked bit by bit: an
// inner-node bit takes a descend step, a leaf bit a descend and a symbol step, since every tree
// memory read address depends on the previous read; closing a word takes an end and a flush step.
// Reset needs no clearing pass; the tree memory is valid only where it was written.
// With both result registers full and the output stalled, the walker holds at every step.
module huffman_tree_stream_decoder
    import hufd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  item_t            item,
    output logic             result_valid,
    input  logic             result_stall,
    output result_t          result,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [LEN_W-1:0] cfg_data
);

    logic [7:0] tree_mem [TREE_BYTES];
    logic [7:0] rdata_reg;
    logic [TREE_AW-1:0] rd_addr;
    logic rd_en;

    state_t state_reg, state_next;
    logic [TREE_AW-1:0] node_reg, node_next;
    logic [3:0] pending_reg, pending_next;
    logic nib_valid_reg, nib_valid_next;
    logic [LEN_W-1:0] bytes_reg, bytes_next;
    logic finished_reg, finished_next;
    logic failed_reg, failed_next;
    logic [31:0] word_reg, word_next;
    logic [BIT_CNT_W-1:0] bits_left_reg, bits_left_next;
    logic final_reg, final_next;
    logic [7:0] size_reg;
    logic mode_reg;
    logic [LEN_W-1:0] length_reg;

    logic accept;
    logic tree_wr;
    logic ready;
    gen_t gen;

    logic [IDX_W-1:0] node_limit_raw, node_limit;
    logic [IDX_W-1:0] child_idx;
    logic [LEN_W-1:0] bytes_inc;
    logic cur_bit;
    logic leaf;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign tree_wr    = accept && (item.cmd == CMD_TREE)
                        && ({1'b0, item.tree_index} < NODE_LIMIT_MAX);

    assign node_limit_raw = ({2'b00, size_reg} + IDX_W'(1)) << 1;
    assign node_limit     = (node_limit_raw > NODE_LIMIT_MAX) ? NODE_LIMIT_MAX
                                                              : node_limit_raw;
    assign cur_bit      = word_reg[31];
    assign child_idx    = {1'b0, node_reg[TREE_AW-1:1], 1'b0}
                          + (({4'b0000, rdata_reg[5:0]} + IDX_W'(1)) << 1)
                          + IDX_W'(cur_bit);
    assign leaf         = cur_bit ? rdata_reg[6] : rdata_reg[7];
    assign bytes_inc    = bytes_reg + LEN_W'(1);

    always_ff @(posedge clk)
    begin
        if (tree_wr)
        begin
            tree_mem[item.tree_index[TREE_AW-1:0]] <= item.tree_byte;
        end
        if (rd_en)
        begin
            rdata_reg <= tree_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        node_next      = node_reg;
        pending_next   = pending_reg;
        nib_valid_next = nib_valid_reg;
        bytes_next     = bytes_reg;
        finished_next  = finished_reg;
        failed_next    = failed_reg;
        word_next      = word_reg;
        bits_left_next = bits_left_reg;
        final_next     = final_reg;
        rd_en          = 1'b0;
        rd_addr        = node_reg;
        gen            = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item.cmd == CMD_TREE)
                    begin
                        // Writing the size byte starts a new stream.
                        if (tree_wr && (item.tree_index == 9'd0))
                        begin
                            node_next      = ROOT_NODE;
                            pending_next   = 4'd0;
                            nib_valid_next = 1'b0;
                            bytes_next     = '0;
                            finished_next  = 1'b0;
                            failed_next    = 1'b0;
                        end
                    end
                    else if (!finished_reg && !failed_reg)
                    begin
                        if (bytes_reg >= length_reg)
                        begin
                            finished_next = 1'b1;
                        end
                        else
                        begin
                            word_next      = item.data_word;
                            bits_left_next = LAST_BIT;
                            final_next     = item.final_word;
                            rd_en          = 1'b1;
                            rd_addr        = node_reg;
                            state_next     = ST_DESC;
                        end
                    end
                end
            end

            ST_DESC:
            begin
                if (ready)
                begin
                    if (({1'b0, node_reg} >= node_limit) || (child_idx >= node_limit))
                    begin
                        gen.push    = 1'b1;
                        gen.res     = '{8'd0, 1'b0, ERR_BAD_NODE};
                        failed_next = 1'b1;
                        state_next  = ST_END;
                    end
                    else
                    begin
                        node_next = child_idx[TREE_AW-1:0];
                        rd_en     = 1'b1;
                        rd_addr   = child_idx[TREE_AW-1:0];
                        if (leaf)
                        begin
                            state_next = ST_SYM;
                        end
                        else if (bits_left_reg == '0)
                        begin
                            state_next = ST_END;
                        end
                        else
                        begin
                            word_next      = word_reg << 1;
                            bits_left_next = bits_left_reg - BIT_CNT_W'(1);
                        end
                    end
                end
            end

            ST_SYM:
            begin
                if (ready)
                begin
                    node_next = ROOT_NODE;
                    rd_en     = 1'b1;
                    rd_addr   = ROOT_NODE;
                    if ((mode_reg == MODE_NIBBLE) && !nib_valid_reg)
                    begin
                        pending_next   = rdata_reg[3:0];
                        nib_valid_next = 1'b1;
                        if (bits_left_reg == '0)
                        begin
                            state_next = ST_END;
                        end
                        else
                        begin
                            word_next      = word_reg << 1;
                            bits_left_next = bits_left_reg - BIT_CNT_W'(1);
                            state_next     = ST_DESC;
                        end
                    end
                    else
                    begin
                        gen.push = 1'b1;
                        if (mode_reg == MODE_BYTE)
                        begin
                            gen.res = '{rdata_reg, bytes_inc == length_reg, ERR_NONE};
                        end
                        else
                        begin
                            gen.res = '{{rdata_reg[3:0], pending_reg},
                                        bytes_inc == length_reg, ERR_NONE};
                            nib_valid_next = 1'b0;
                            pending_next   = 4'd0;
                        end
                        bytes_next = bytes_inc;
                        if (bytes_inc >= length_reg)
                        begin
                            finished_next = 1'b1;
                            state_next    = ST_END;
                        end
                        else if (bits_left_reg == '0)
                        begin
                            state_next = ST_END;
                        end
                        else
                        begin
                            word_next      = word_reg << 1;
                            bits_left_next = bits_left_reg - BIT_CNT_W'(1);
                            state_next     = ST_DESC;
                        end
                    end
                end
            end

            ST_END:
            begin
                if (ready)
                begin
                    if (!finished_reg && !failed_reg && final_reg)
                    begin
                        gen.push    = 1'b1;
                        gen.res     = '{8'd0, 1'b0, ERR_EARLY_END};
                        failed_next = 1'b1;
                    end
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (ready)
                begin
                    gen.flush  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            node_reg      <= ROOT_NODE;
            pending_reg   <= 4'd0;
            nib_valid_reg <= 1'b0;
            bytes_reg     <= '0;
            finished_reg  <= 1'b0;
            failed_reg    <= 1'b0;
            mode_reg      <= MODE_BYTE;
            length_reg    <= LEN_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            node_reg      <= node_next;
            pending_reg   <= pending_next;
            nib_valid_reg <= nib_valid_next;
            bytes_reg     <= bytes_next;
            finished_reg  <= finished_next;
            failed_reg    <= failed_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_LENGTH: length_reg <= cfg_data;
                    default:    mode_reg   <= mode_reg;
                endcase
            end
        end
    end

    // Word shifter and a copy of the size byte, so the table limit needs no memory read.
    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        bits_left_reg <= bits_left_next;
        final_reg     <= final_next;
        if (tree_wr && (item.tree_index == 9'd0))
        begin
            size_reg <= item.tree_byte;
        end
    end

    hufd_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .gen          (gen),
        .ready        (ready),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule
